// ===== design/fts_pkg.sv =====
package fts_pkg;

  // Table size and derived index width
  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);

  // Field widths
  localparam int ID_W  = 8;
  localparam int VR_W  = 32;
  localparam int REM_W = 16;
  localparam int ORD_W = 32;

  localparam logic [VR_W-1:0] VR_MAX = '1;

  // Operation codes of the command channel
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // One table entry as stored in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [VR_W-1:0]  vr;
    logic [REM_W-1:0] rem;
    logic [ORD_W-1:0] ord;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Control sequencer
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

endpackage

// ===== design/fts_if.sv =====
// Command channel: arrivals and ticks
interface fts_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [fts_pkg::ID_W-1:0]  task_id;
  logic [fts_pkg::REM_W-1:0] burst;

  modport source (output valid, op, task_id, burst, input ready);
  modport sink   (input valid, op, task_id, burst, output ready);
endinterface

// Result channel: one beat per tick
interface fts_out_if;
  logic                     valid;
  logic                     ready;
  logic                     idle;
  logic [fts_pkg::ID_W-1:0] run_id;
  logic [fts_pkg::VR_W-1:0] run_vruntime;
  logic                     completed;

  modport source (output valid, idle, run_id, run_vruntime, completed, input ready);
  modport sink   (input valid, idle, run_id, run_vruntime, completed, output ready);
endinterface

// ===== design/fts_ram.sv =====
module fts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/fair_share_task_scheduler.sv =====
// Fair-share tick scheduler.
// cmd channel (valid/ready): op=0 adds a waiting task (task_id, burst) with
// zero runtime into the first free slot, dropped if the table is full;
// op=1 is a scheduler tick. res channel (valid/ready): one beat per tick
// with the task that ran, its runtime before the tick and a completion
// flag, or an idle beat when nothing could run.
// A tick walks the whole slot memory through its single read port, one
// entry a cycle, then the decide step loads the result beat and returns
// to idle; no command is taken until then.
// Waiting-task state sits in one slot memory (MAX_TASKS entries); only the
// per-slot valid bits and the running task are in flops.
// Reset (synchronous, rst high) clears the valid bits, order counter and
// running task; the slot memory needs no clearing pass.
// A stalled res channel holds its beat. Arrivals are still taken meanwhile,
// and a following tick scans but waits to commit until the beat is taken.
module fair_share_task_scheduler (
  input logic       clk,
  input logic       rst,
  fts_in_if.sink    cmd,
  fts_out_if.source res
);

  localparam int IDX_W = fts_pkg::IDX_W;

  fts_pkg::state_t                state;
  logic [fts_pkg::MAX_TASKS-1:0]  slot_valid;
  logic [fts_pkg::ORD_W-1:0]      order_counter;
  logic                           busy;
  logic [fts_pkg::ID_W-1:0]       cur_id;
  logic [fts_pkg::VR_W-1:0]       cur_vr;
  logic [fts_pkg::REM_W-1:0]      cur_rem;

  // Scan pipeline
  logic [IDX_W:0]                 iss;
  logic                           data_vld;
  logic [IDX_W-1:0]               data_idx;
  logic                           best_found;
  logic [IDX_W-1:0]               best_idx;
  fts_pkg::slot_t                 best;

  // Memory ports
  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;
  fts_pkg::slot_t                 wr_data;
  logic                           rd_en;
  fts_pkg::slot_t                 rd_data;

  logic                           cmd_fire;
  logic                           out_free;
  logic                           commit;
  logic                           free_found;
  logic [IDX_W-1:0]               free_idx;
  logic                           cand_better;
  logic                           take;
  logic                           run_idle;
  logic [fts_pkg::ID_W-1:0]       sel_id;
  logic [fts_pkg::VR_W-1:0]       sel_vr;
  logic [fts_pkg::VR_W-1:0]       sel_vr_inc;
  logic [fts_pkg::REM_W-1:0]      sel_rem;
  logic                           sel_done;

  assign cmd.ready = (state == fts_pkg::S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_free  = !res.valid || res.ready;
  assign commit    = (state == fts_pkg::S_DECIDE) && out_free;

  // First free slot, lowest index wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = fts_pkg::MAX_TASKS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Running minimum: smaller runtime, then earlier order
  assign cand_better = slot_valid[data_idx] &&
                       (!best_found || (rd_data.vr < best.vr) ||
                        ((rd_data.vr == best.vr) && (rd_data.ord < best.ord)));

  // Tick decision
  assign take     = best_found && (!busy || (cur_vr > best.vr));
  assign run_idle = !busy && !best_found;
  assign sel_id   = take ? best.id  : cur_id;
  assign sel_vr   = take ? best.vr  : cur_vr;
  assign sel_rem  = take ? best.rem : cur_rem;
  assign sel_vr_inc = (sel_vr == fts_pkg::VR_MAX) ? sel_vr : sel_vr + 1'b1;
  assign sel_done = (sel_rem <= fts_pkg::REM_W'(1));

  // Memory access: arrivals write in idle, a preempted task goes back into
  // the slot its replacement vacated
  assign rd_en = (state == fts_pkg::S_SCAN) && (iss < (IDX_W + 1)'(fts_pkg::MAX_TASKS));
  assign wr_en = (cmd_fire && (cmd.op == fts_pkg::OP_ARRIVE) && free_found) ||
                 (commit && take && busy);
  assign wr_addr = (state == fts_pkg::S_DECIDE) ? best_idx : free_idx;

  always_comb begin
    if (state == fts_pkg::S_DECIDE) begin
      wr_data = '{id: cur_id, vr: cur_vr, rem: cur_rem, ord: order_counter};
    end else begin
      wr_data = '{id: cmd.task_id, vr: '0, rem: cmd.burst, ord: order_counter};
    end
  end

  fts_ram #(
    .WIDTH (fts_pkg::SLOT_W),
    .DEPTH (fts_pkg::MAX_TASKS)
  ) u_slots (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (iss[IDX_W-1:0]),
    .rdata (rd_data)
  );

  // Sequencer, table bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fts_pkg::S_IDLE;
      slot_valid    <= '0;
      order_counter <= '0;
      busy          <= 1'b0;
      cur_id        <= '0;
      cur_vr        <= '0;
      cur_rem       <= '0;
      iss           <= '0;
      data_vld      <= 1'b0;
      best_found    <= 1'b0;
      res.valid     <= 1'b0;
    end else begin
      if (wr_en) begin
        order_counter <= order_counter + 1'b1;
      end
      // beat taken and no new one loaded this cycle
      if (res.ready && !commit) begin
        res.valid <= 1'b0;
      end
      case (state)
        fts_pkg::S_IDLE: begin
          if (cmd_fire) begin
            if (cmd.op == fts_pkg::OP_ARRIVE) begin
              if (free_found) begin
                slot_valid[free_idx] <= 1'b1;
              end
            end else begin
              state      <= fts_pkg::S_SCAN;
              iss        <= '0;
              data_vld   <= 1'b0;
              best_found <= 1'b0;
            end
          end
        end
        fts_pkg::S_SCAN: begin
          if (rd_en) begin
            iss <= iss + 1'b1;
          end
          data_vld <= rd_en;
          data_idx <= iss[IDX_W-1:0];
          if (data_vld && cand_better) begin
            best_found <= 1'b1;
            best_idx   <= data_idx;
            best       <= rd_data;
          end
          if (data_vld && (data_idx == IDX_W'(fts_pkg::MAX_TASKS - 1))) begin
            state <= fts_pkg::S_DECIDE;
          end
        end
        fts_pkg::S_DECIDE: begin
          if (out_free) begin
            res.valid <= 1'b1;
            state     <= fts_pkg::S_IDLE;
            if (run_idle) begin
              res.idle         <= 1'b1;
              res.run_id       <= '0;
              res.run_vruntime <= '0;
              res.completed    <= 1'b0;
            end else begin
              res.idle         <= 1'b0;
              res.run_id       <= sel_id;
              res.run_vruntime <= sel_vr;
              res.completed    <= sel_done;
              // a fresh start frees the slot; a preemption refills it
              if (take && !busy) begin
                slot_valid[best_idx] <= 1'b0;
              end
              cur_id  <= sel_id;
              cur_vr  <= sel_vr_inc;
              cur_rem <= sel_done ? '0 : sel_rem - 1'b1;
              busy    <= !sel_done;
            end
          end
        end
        default: begin
          state <= fts_pkg::S_IDLE;
        end
      endcase
    end
  end

  // A result beat only comes out of the decide step
  a_beat_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> ($past(state) == fts_pkg::S_DECIDE))
    else $error("result beat not produced by a tick decision");

  // An idle beat means the scan really found an empty table
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (commit && run_idle) |-> (slot_valid == '0))
    else $error("idle result while waiting tasks exist");

  // A running task always has work left
  a_busy_work: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cur_rem != '0))
    else $error("running task with no remaining work");

  // The memory is never written during a scan
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((state == fts_pkg::S_IDLE) || (state == fts_pkg::S_DECIDE)))
    else $error("slot write during scan");

endmodule
